/* sv/pdlr_pkg.sv */
// ----------------------------------------------------------------------------
// pdlr_pkg
// Shared widths, state and register codes, and sample conversion helpers for
// the downmix and linear resampler core.
// ----------------------------------------------------------------------------
package pdlr_pkg;

    localparam int MAX_RATIO_DEF = 24;

    localparam int SAMPLE_W  = 16;
    localparam int RATE_W    = 18;
    localparam int CNT_W     = 32;
    localparam int ACC_W     = 64;
    localparam int FRAC_W    = 32;
    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 32;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNELS  = 3'd0,
        REG_WIDE      = 3'd1,
        REG_SRC_RATE  = 3'd2,
        REG_DST_RATE  = 3'd3,
        REG_FRAMES    = 3'd4,
        REG_MAX_OUT   = 3'd5
    } t_cfg_reg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DERIVE,
        ST_DIV_STEP,
        ST_MUL_LIM,
        ST_DIV_LIM,
        ST_DISPATCH,
        ST_LOOP,
        ST_LERP,
        ST_TAIL,
        ST_PUSH,
        ST_FINISH
    } t_state;

    // raw channel sample to signed 16-bit
    function automatic logic signed [SAMPLE_W-1:0] to_s16(
        input logic                wide,
        input logic [SAMPLE_W-1:0] raw
    );
        logic signed [SAMPLE_W-1:0] res;
        if (wide) begin
            res = signed'(raw);
        end else begin
            res = signed'({~raw[7], raw[6:0], 8'h00});
        end
        return res;
    endfunction

    // average of both channels, truncated toward zero; the first channel alone when mono
    function automatic logic signed [SAMPLE_W-1:0] downmix(
        input logic [1:0]          chans,
        input logic                wide,
        input logic [SAMPLE_W-1:0] first_raw,
        input logic [SAMPLE_W-1:0] second_raw
    );
        logic signed [SAMPLE_W-1:0] s0;
        logic signed [SAMPLE_W-1:0] s1;
        logic signed [SAMPLE_W:0]   sum;
        logic signed [SAMPLE_W:0]   adj;
        logic signed [SAMPLE_W-1:0] res;
        s0  = to_s16(wide, first_raw);
        s1  = to_s16(wide, second_raw);
        sum = (SAMPLE_W+1)'(s0) + (SAMPLE_W+1)'(s1);
        adj = sum + (SAMPLE_W+1)'(sum[SAMPLE_W]);
        if (chans == 2'd1) begin
            res = s0;
        end else begin
            res = adj[SAMPLE_W:1];
        end
        return res;
    endfunction

endpackage

/* sv/pdlr_div.sv */
// ----------------------------------------------------------------------------
// pdlr_div
// Bit-serial restoring divider: one quotient bit per cycle over the full
// dividend width.
// ----------------------------------------------------------------------------
module pdlr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pdlr_pkg::ACC_W-1:0]    i_dividend,
    input  logic [pdlr_pkg::RATE_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [pdlr_pkg::ACC_W-1:0]    o_quot
);
    localparam int CW = $clog2(pdlr_pkg::ACC_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CW-1:0]                 r_cnt;
    logic [pdlr_pkg::ACC_W-1:0]    r_quot;
    logic [pdlr_pkg::RATE_W-1:0]   r_rem;
    logic [pdlr_pkg::RATE_W-1:0]   r_div;

    logic [pdlr_pkg::RATE_W:0]     w_trial;
    logic [pdlr_pkg::RATE_W:0]     w_diff;
    logic                          w_ge;

    // one trial subtraction
    always_comb begin
        w_trial = {r_rem, r_quot[pdlr_pkg::ACC_W-1]};
        w_ge    = w_trial >= {1'b0, r_div};
        w_diff  = w_trial - {1'b0, r_div};
    end

    // shift quotient bits in, remainder stays below the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_quot <= '0;
            r_rem  <= '0;
            r_div  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[pdlr_pkg::RATE_W-1:0]
                               : w_trial[pdlr_pkg::RATE_W-1:0];
                r_quot <= {r_quot[pdlr_pkg::ACC_W-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CW'(pdlr_pkg::ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* sv/pdlr_mul.sv */
// ----------------------------------------------------------------------------
// pdlr_mul
// Bit-serial shift-add multiplier: signed multiplicand times unsigned
// multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pdlr_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [pdlr_pkg::MUL_A_W-1:0]  i_a,
    input  logic        [pdlr_pkg::MUL_B_W-1:0]  i_b,
    output logic                                 o_done,
    output logic signed [pdlr_pkg::PROD_W-1:0]   o_prod
);
    localparam int CW = $clog2(pdlr_pkg::MUL_B_W);

    logic                                 r_busy;
    logic                                 r_done;
    logic [CW-1:0]                        r_cnt;
    logic signed [pdlr_pkg::PROD_W-1:0]   r_mc;
    logic [pdlr_pkg::MUL_B_W-1:0]         r_mp;
    logic signed [pdlr_pkg::PROD_W-1:0]   r_prod;

    // add shifted multiplicand for each set multiplier bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mc   <= '0;
            r_mp   <= '0;
            r_prod <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_mc   <= pdlr_pkg::PROD_W'(i_a);
                r_mp   <= i_b;
                r_prod <= '0;
            end else if (r_busy) begin
                if (r_mp[0]) begin
                    r_prod <= r_prod + r_mc;
                end
                r_mc  <= r_mc <<< 1;
                r_mp  <= r_mp >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(pdlr_pkg::MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

/* sv/pcm_downmix_linear_resampler_core.sv */
// ----------------------------------------------------------------------------
// pcm_downmix_linear_resampler_core
// Downmixes PCM frames to signed 16-bit mono and resamples them by q32.32
// linear interpolation, giving zero or more samples per frame.
//
//   channel  direction  handshake                payload
//   input    in         i_valid / o_ready        i_first_raw, i_second_raw
//   output   out        o_valid / i_ready        o_mono_sample, o_run_last
//   config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One frame at a time. When resampling, the first frame of a clip runs the
// serial divider for the step and, with two or more frames, the serial
// multiplier and the divider again for the output limit. Each interpolated
// sample goes through the serial multiplier; skipped and repeated ones do not.
// Synchronous active-low reset; no clearing pass. A stalled output holds
// one sample in the output register and one pending, then the sequencer waits.
// Register writes are taken only while idle with the output register empty.
// ----------------------------------------------------------------------------
module pcm_downmix_linear_resampler_core #(
    parameter int MAX_RATIO = pdlr_pkg::MAX_RATIO_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [pdlr_pkg::SAMPLE_W-1:0]         i_first_raw,
    input  logic [pdlr_pkg::SAMPLE_W-1:0]         i_second_raw,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [pdlr_pkg::SAMPLE_W-1:0]  o_mono_sample,
    output logic                                  o_run_last,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pdlr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pdlr_pkg::CFG_DAT_W-1:0]        i_cfg_data
);
    localparam int N_W = $clog2(MAX_RATIO + 1);
    localparam int SW  = pdlr_pkg::SAMPLE_W;
    localparam int RW  = pdlr_pkg::RATE_W;
    localparam int CW  = pdlr_pkg::CNT_W;
    localparam int AW  = pdlr_pkg::ACC_W;
    localparam int FW  = pdlr_pkg::FRAC_W;

    pdlr_pkg::t_state r_state, n_state;
    pdlr_pkg::t_state r_ret;

    // configuration
    logic [1:0]     r_chans;
    logic           r_wide;
    logic [RW-1:0]  r_src_rate;
    logic [RW-1:0]  r_dst_rate;
    logic [CW-1:0]  r_frames;
    logic [CW-1:0]  r_max_out;

    // clip state
    logic [AW-1:0]         r_acc;
    logic [AW-1:0]         r_step;
    logic signed [SW-1:0]  r_prev;
    logic signed [SW-1:0]  r_cur;
    logic [CW-1:0]         r_seen;
    logic [CW-1:0]         r_done;
    logic [CW-1:0]         r_limit;
    logic [CW-1:0]         r_j;
    logic                  r_fmt_ok;
    logic [N_W-1:0]        r_n;

    // pending sample and output register
    logic                  r_pend_v;
    logic signed [SW-1:0]  r_pend;
    logic signed [SW-1:0]  r_val;
    logic                  r_out_v;
    logic signed [SW-1:0]  r_out;
    logic                  r_out_last;

    // serial units
    logic                                 w_div_start;
    logic [AW-1:0]                        w_div_dividend;
    logic [RW-1:0]                        w_div_divisor;
    logic                                 w_div_done;
    logic [AW-1:0]                        w_div_quot;
    logic                                 w_mul_start;
    logic signed [pdlr_pkg::MUL_A_W-1:0]  w_mul_a;
    logic [pdlr_pkg::MUL_B_W-1:0]         w_mul_b;
    logic                                 w_mul_done;
    logic signed [pdlr_pkg::PROD_W-1:0]   w_mul_prod;

    logic [RW-1:0]         w_src;
    logic                  w_passthru;
    logic [CW-1:0]         w_min_frames;
    logic                  w_slot_free;
    logic                  w_more;
    logic                  w_in_run;
    logic                  w_cond;
    logic                  w_n_room;
    logic                  w_push_go;
    logic                  w_load;
    logic signed [SW+1:0]  w_lerp;
    logic signed [SW-1:0]  w_mix;

    // derived comparisons
    always_comb begin
        w_src        = (r_src_rate != '0) ? r_src_rate : r_dst_rate;
        w_passthru   = (w_src == r_dst_rate);
        w_min_frames = (r_frames < r_max_out) ? r_frames : r_max_out;
        w_slot_free  = !r_out_v || i_ready;
        w_more       = r_done < r_limit;
        w_in_run     = r_acc[AW-1:FW] <= (r_j - 1'b1);
        w_cond       = w_more && w_in_run;
        w_n_room     = r_n < N_W'(MAX_RATIO);
        w_push_go    = !r_pend_v || w_slot_free;
        w_load       = ((r_state == pdlr_pkg::ST_PUSH) || (r_state == pdlr_pkg::ST_FINISH))
                    && w_push_go && r_pend_v;
        w_lerp       = (SW+2)'(r_prev) + w_mul_prod[FW+SW+1:FW];
        w_mix        = pdlr_pkg::downmix(r_chans, r_wide, i_first_raw, i_second_raw);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pdlr_pkg::ST_IDLE: begin
                if (i_valid && o_ready && (r_seen < r_frames)) begin
                    n_state = (r_seen == '0) ? pdlr_pkg::ST_DERIVE : pdlr_pkg::ST_DISPATCH;
                end
            end
            pdlr_pkg::ST_DERIVE: begin
                if ((r_dst_rate == '0) || w_passthru) begin
                    n_state = pdlr_pkg::ST_DISPATCH;
                end else begin
                    n_state = pdlr_pkg::ST_DIV_STEP;
                end
            end
            pdlr_pkg::ST_DIV_STEP: begin
                if (w_div_done) begin
                    n_state = (r_frames < CW'(2)) ? pdlr_pkg::ST_DISPATCH
                                                  : pdlr_pkg::ST_MUL_LIM;
                end
            end
            pdlr_pkg::ST_MUL_LIM: begin
                if (w_mul_done) n_state = pdlr_pkg::ST_DIV_LIM;
            end
            pdlr_pkg::ST_DIV_LIM: begin
                if (w_div_done) n_state = pdlr_pkg::ST_DISPATCH;
            end
            pdlr_pkg::ST_DISPATCH: begin
                if (!r_fmt_ok) begin
                    n_state = pdlr_pkg::ST_FINISH;
                end else if (r_step == '0) begin
                    n_state = w_more ? pdlr_pkg::ST_PUSH : pdlr_pkg::ST_FINISH;
                end else if (r_j != '0) begin
                    n_state = pdlr_pkg::ST_LOOP;
                end else begin
                    n_state = pdlr_pkg::ST_FINISH;
                end
            end
            pdlr_pkg::ST_LOOP: begin
                if (w_cond) begin
                    n_state = w_n_room ? pdlr_pkg::ST_LERP : pdlr_pkg::ST_LOOP;
                end else if (r_j == (r_frames - 1'b1)) begin
                    n_state = pdlr_pkg::ST_TAIL;
                end else begin
                    n_state = pdlr_pkg::ST_FINISH;
                end
            end
            pdlr_pkg::ST_LERP: begin
                if (w_mul_done) n_state = pdlr_pkg::ST_PUSH;
            end
            pdlr_pkg::ST_TAIL: begin
                n_state = (w_more && w_n_room) ? pdlr_pkg::ST_PUSH : pdlr_pkg::ST_FINISH;
            end
            pdlr_pkg::ST_PUSH: begin
                if (w_push_go) n_state = r_ret;
            end
            pdlr_pkg::ST_FINISH: begin
                if (w_push_go) n_state = pdlr_pkg::ST_IDLE;
            end
            default: n_state = pdlr_pkg::ST_IDLE;
        endcase
    end

    // unit starts and operand selection
    always_comb begin
        o_ready     = (r_state == pdlr_pkg::ST_IDLE) && !i_cfg_valid;
        o_cfg_ready = (r_state == pdlr_pkg::ST_IDLE) && !r_out_v;
        w_div_start = ((r_state == pdlr_pkg::ST_DERIVE) && (r_dst_rate != '0) && !w_passthru)
                   || ((r_state == pdlr_pkg::ST_MUL_LIM) && w_mul_done);
        if (r_state == pdlr_pkg::ST_DERIVE) begin
            w_div_dividend = {(AW-RW-FW)'(0), w_src, FW'(0)};
            w_div_divisor  = r_dst_rate;
        end else begin
            w_div_dividend = w_mul_prod[AW-1:0];
            w_div_divisor  = w_src;
        end
        w_mul_start = ((r_state == pdlr_pkg::ST_DIV_STEP) && w_div_done
                       && (r_frames >= CW'(2)))
                   || ((r_state == pdlr_pkg::ST_LOOP) && w_cond && w_n_room);
        if (r_state == pdlr_pkg::ST_DIV_STEP) begin
            w_mul_a = pdlr_pkg::MUL_A_W'({1'b0, r_frames - 1'b1});
            w_mul_b = pdlr_pkg::MUL_B_W'(r_dst_rate);
        end else begin
            w_mul_a = pdlr_pkg::MUL_A_W'((SW+1)'(r_cur) - (SW+1)'(r_prev));
            w_mul_b = r_acc[FW-1:0];
        end
    end

    pdlr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    pdlr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdlr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration, clip state and output path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chans    <= 2'd1;
            r_wide     <= 1'b1;
            r_src_rate <= '0;
            r_dst_rate <= RW'(48000);
            r_frames   <= '0;
            r_max_out  <= '0;
            r_acc      <= '0;
            r_step     <= '0;
            r_prev     <= '0;
            r_cur      <= '0;
            r_seen     <= '0;
            r_done     <= '0;
            r_limit    <= '0;
            r_j        <= '0;
            r_fmt_ok   <= 1'b0;
            r_n        <= '0;
            r_ret      <= pdlr_pkg::ST_IDLE;
            r_pend_v   <= 1'b0;
            r_pend     <= '0;
            r_val      <= '0;
            r_out_v    <= 1'b0;
            r_out      <= '0;
            r_out_last <= 1'b0;
        end else begin
            // output register loads from the pending slot or drains on request
            if (w_load) begin
                r_out_v    <= 1'b1;
                r_out      <= r_pend;
                r_out_last <= (r_state == pdlr_pkg::ST_FINISH);
            end else if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end

            // a write to a defined register restarts the clip
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pdlr_pkg::REG_CHANNELS: r_chans    <= i_cfg_data[1:0];
                    pdlr_pkg::REG_WIDE:     r_wide     <= i_cfg_data[0];
                    pdlr_pkg::REG_SRC_RATE: r_src_rate <= i_cfg_data[RW-1:0];
                    pdlr_pkg::REG_DST_RATE: r_dst_rate <= i_cfg_data[RW-1:0];
                    pdlr_pkg::REG_FRAMES:   r_frames   <= i_cfg_data;
                    pdlr_pkg::REG_MAX_OUT:  r_max_out  <= i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index <= pdlr_pkg::CFG_IDX_W'(pdlr_pkg::REG_MAX_OUT)) begin
                    r_acc  <= '0;
                    r_prev <= '0;
                    r_seen <= '0;
                    r_done <= '0;
                end
            end

            case (r_state)
                pdlr_pkg::ST_IDLE: begin
                    if (i_valid && o_ready && (r_seen < r_frames)) begin
                        r_seen   <= r_seen + 1'b1;
                        r_j      <= r_seen;
                        r_n      <= '0;
                        r_fmt_ok <= (r_chans != 2'd0);
                        r_cur    <= (r_chans != 2'd0) ? w_mix : '0;
                    end
                end
                pdlr_pkg::ST_DERIVE: begin
                    if (r_dst_rate == '0) begin
                        r_step  <= '0;
                        r_limit <= '0;
                    end else if (w_passthru) begin
                        r_step  <= '0;
                        r_limit <= w_min_frames;
                    end
                end
                pdlr_pkg::ST_DIV_STEP: begin
                    if (w_div_done) begin
                        r_step <= w_div_quot;
                        if (r_frames < CW'(2)) r_limit <= '0;
                    end
                end
                pdlr_pkg::ST_DIV_LIM: begin
                    if (w_div_done) begin
                        r_limit <= (w_div_quot > AW'(r_max_out)) ? r_max_out
                                                                 : w_div_quot[CW-1:0];
                    end
                end
                pdlr_pkg::ST_DISPATCH: begin
                    r_val <= r_cur;
                    r_ret <= pdlr_pkg::ST_FINISH;
                end
                pdlr_pkg::ST_LOOP: begin
                    // outputs past the per-frame cap still advance
                    if (w_cond && !w_n_room) begin
                        r_done <= r_done + 1'b1;
                        r_acc  <= r_acc + r_step;
                    end
                end
                pdlr_pkg::ST_LERP: begin
                    r_val <= w_lerp[SW-1:0];
                    r_ret <= pdlr_pkg::ST_LOOP;
                end
                pdlr_pkg::ST_TAIL: begin
                    r_val <= r_cur;
                    r_ret <= pdlr_pkg::ST_TAIL;
                    if (!(w_more && w_n_room)) r_done <= r_limit;
                end
                pdlr_pkg::ST_PUSH: begin
                    if (w_push_go) begin
                        r_pend_v <= 1'b1;
                        r_pend   <= r_val;
                        r_n      <= r_n + 1'b1;
                        r_done   <= r_done + 1'b1;
                        r_acc    <= r_acc + r_step;
                    end
                end
                pdlr_pkg::ST_FINISH: begin
                    if (w_push_go) begin
                        r_pend_v <= 1'b0;
                        r_prev   <= r_cur;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = r_out_v;
    assign o_mono_sample = r_out;
    assign o_run_last    = r_out_last;

    // a held sample never outlives its frame
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pdlr_pkg::ST_IDLE) |-> !r_pend_v)
        else $error("pending sample left while idle");

    // output count never passes the clip limit
    a_done_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != pdlr_pkg::ST_IDLE) |-> (r_done <= r_limit))
        else $error("output count beyond limit");

    // per-frame count bounded by the ratio cap
    a_n_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= N_W'(MAX_RATIO))
        else $error("too many samples for one frame");

    // a sample is loaded only into a free output slot
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_ready) |=> (r_out_v && $stable(r_out) && $stable(r_out_last)))
        else $error("stalled output overwritten");

endmodule

/* tb/pcm_downmix_linear_resampler_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcm_downmix_linear_resampler_core_tb
// Drives PCM frames through the downmix and linear resampler core over many
// clip settings, predicts every output sample with an independent resampler
// model and checks each returned sample and its run marker in order.
// ----------------------------------------------------------------------------
module pcm_downmix_linear_resampler_core_tb;

    localparam int  RATIO_CAP   = 24;
    localparam int  SETTLE_CYC  = 12000;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  FRAME_GOAL  = 260;

    typedef struct {
        logic [15:0] first;
        logic [15:0] second;
    } t_pcm_frame;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } t_mono_out;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_ready;
    logic [15:0] i_first_raw  = '0;
    logic [15:0] i_second_raw = '0;
    logic        o_valid;
    logic        i_ready      = 1'b0;
    logic signed [15:0] o_mono_sample;
    logic        o_run_last;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [pdlr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [pdlr_pkg::CFG_DAT_W-1:0] i_cfg_data  = '0;

    t_pcm_frame pending_frames[$];
    t_mono_out  expected_mono[$];
    int         err_count   = 0;
    int         cycle_count = 0;
    int         frames_sent = 0;
    int         ready_pct   = 100;
    bit         gaps_on     = 1'b0;
    int         burst_left  = 1;
    int         gap_left    = 0;

    // resampler model state and register copies
    logic [1:0]  m_chans;
    logic        m_wide;
    logic [17:0] m_src_rate;
    logic [17:0] m_dst_rate;
    logic [31:0] m_frame_cnt;
    logic [31:0] m_max_out;
    logic [63:0] m_acc;
    logic [63:0] m_step;
    int          m_prev;
    logic [31:0] m_seen;
    logic [31:0] m_done;
    logic [31:0] m_limit;

    pcm_downmix_linear_resampler_core DUT (.*);

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic int raw_to_s16(input logic [15:0] raw);
        if (m_wide) return int'(signed'(raw));
        return (int'(raw[7:0]) - 128) * 256;
    endfunction

    function automatic int lerp_sample(input int a, input int b, input logic [31:0] frac);
        longint prod;
        prod = longint'(b - a) * longint'({32'b0, frac});
        // arithmetic shift rounds toward minus infinity
        return a + int'(prod >>> 32);
    endfunction

    // step and output limit, latched at the first frame of a clip
    task automatic latch_rates();
        logic [17:0] src;
        logic [63:0] prod;
        src = (m_src_rate != 0) ? m_src_rate : m_dst_rate;
        if (m_dst_rate == 0) begin
            m_step  = '0;
            m_limit = '0;
        end else if (src == m_dst_rate) begin
            m_step  = '0;
            m_limit = (m_frame_cnt < m_max_out) ? m_frame_cnt : m_max_out;
        end else begin
            m_step = {14'b0, src, 32'b0} / 64'(m_dst_rate);
            if (m_frame_cnt < 2) begin
                m_limit = '0;
            end else begin
                prod    = (64'(m_frame_cnt - 1) * 64'(m_dst_rate)) / 64'(src);
                m_limit = (prod > 64'(m_max_out)) ? m_max_out : prod[31:0];
            end
        end
    endtask

    // one output sample, dropped beyond the per-frame cap but still counted
    task automatic emit_sample(inout int n, input int v);
        t_mono_out e;
        if (n < RATIO_CAP) begin
            e.sample = v[15:0];
            e.last   = 1'b0;
            expected_mono.push_back(e);
            n++;
        end
        m_done++;
    endtask

    task automatic resample_frame(input logic [15:0] a, input logic [15:0] b);
        int          n;
        int          cur;
        logic [31:0] j;
        n = 0;
        j = m_seen;
        if (j >= m_frame_cnt) return;
        if (j == 0) latch_rates();
        m_seen = j + 1;
        if (m_chans == 0) cur = 0;
        else if (m_chans == 2'd1) cur = raw_to_s16(a);
        else cur = (raw_to_s16(a) + raw_to_s16(b)) / 2;
        if (m_chans != 0) begin
            if (m_step == 0) begin
                if (m_done < m_limit) emit_sample(n, cur);
            end else if (j >= 1) begin
                while (m_done < m_limit && m_acc[63:32] <= j - 1) begin
                    emit_sample(n, lerp_sample(m_prev, cur, m_acc[31:0]));
                    m_acc += m_step;
                end
                // last source frame: repeat its value up to the limit or the per-frame cap
                if (j == m_frame_cnt - 1) begin
                    while (m_done < m_limit && n < RATIO_CAP) begin
                        emit_sample(n, cur);
                        m_acc += m_step;
                    end
                    m_done = m_limit;
                end
            end
        end
        m_prev = cur;
        if (n > 0) expected_mono[$].last = 1'b1;
    endtask

    task automatic model_reset();
        m_chans = 2'd1; m_wide = 1'b1; m_src_rate = '0; m_dst_rate = 18'd48000;
        m_frame_cnt = '0; m_max_out = '0; m_step = '0; m_limit = '0;
        m_acc = '0; m_prev = 0; m_seen = '0; m_done = '0;
    endtask

    // one register write request, then the model follows
    task automatic write_reg(input pdlr_pkg::t_cfg_reg idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            pdlr_pkg::REG_CHANNELS: m_chans     = val[1:0];
            pdlr_pkg::REG_WIDE:     m_wide      = val[0];
            pdlr_pkg::REG_SRC_RATE: m_src_rate  = val[17:0];
            pdlr_pkg::REG_DST_RATE: m_dst_rate  = val[17:0];
            pdlr_pkg::REG_FRAMES:   m_frame_cnt = val;
            pdlr_pkg::REG_MAX_OUT:  m_max_out   = val;
            default: ;
        endcase
        m_acc = '0; m_prev = 0; m_seen = '0; m_done = '0;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_clip(input logic [1:0] chans, input logic wide,
                            input logic [17:0] src, input logic [17:0] dst,
                            input logic [31:0] frames, input logic [31:0] max_out);
        write_reg(pdlr_pkg::REG_CHANNELS, 32'(chans));
        write_reg(pdlr_pkg::REG_WIDE, 32'(wide));
        write_reg(pdlr_pkg::REG_SRC_RATE, 32'(src));
        write_reg(pdlr_pkg::REG_DST_RATE, 32'(dst));
        write_reg(pdlr_pkg::REG_FRAMES, frames);
        write_reg(pdlr_pkg::REG_MAX_OUT, max_out);
    endtask

    task automatic queue_frame(input logic [15:0] a, input logic [15:0] b);
        t_pcm_frame f;
        f.first  = a;
        f.second = b;
        pending_frames.push_back(f);
        frames_sent++;
    endtask

    task automatic queue_random(input int count);
        for (int k = 0; k < count; k++) begin
            queue_frame(16'($urandom), 16'($urandom));
        end
    endtask

    // all frames taken, all samples back, then room for skipped-sample runs
    task automatic drain();
        while (pending_frames.size() > 0 || i_valid || expected_mono.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // frame request driver
    always @(posedge i_clk) begin : frame_driver
        logic       nxt_valid;
        t_pcm_frame f;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nxt_valid = i_valid;
            if (i_valid && o_ready) begin
                resample_frame(i_first_raw, i_second_raw);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_frames.size() > 0) begin
                    f = pending_frames.pop_front();
                    i_first_raw  <= f.first;
                    i_second_raw <= f.second;
                    nxt_valid = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 8);
                        gap_left   = gaps_on ? $urandom_range(0, 6) : 0;
                    end else begin
                        burst_left--;
                    end
                end
            end
            i_valid <= nxt_valid;
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(1, 100) <= ready_pct);
    end

    // output sample checker
    always @(posedge i_clk) begin : sample_checker
        t_mono_out e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_mono.size() == 0) begin
                report($sformatf("unexpected sample %0d", o_mono_sample));
            end else begin
                e = expected_mono.pop_front();
                if (o_mono_sample !== e.sample)
                    report($sformatf("sample got %0d want %0d", o_mono_sample, e.sample));
                if (o_run_last !== e.last)
                    report($sformatf("run_last got %b want %b", o_run_last, e.last));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        logic [17:0] src;
        logic [17:0] dst;
        logic [31:0] frames;
        logic [31:0] max_out;
        int          nfr;
        model_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty clip, frame ignored
        queue_frame(16'h1234, 16'h0000);
        drain();
        // pass-through, mono 16-bit extremes, plus an excess frame
        set_clip(2'd1, 1'b1, 18'd0, 18'd48000, 32'd4, 32'hFFFF_FFFF);
        queue_frame(16'h0000, 16'hFFFF);
        queue_frame(16'h7FFF, 16'h0000);
        queue_frame(16'h8000, 16'hFFFF);
        queue_frame(16'hFFFF, 16'h0000);
        queue_frame(16'h5555, 16'h5555);
        drain();
        // equal rates, stereo 8-bit, capped output
        set_clip(2'd2, 1'b0, 18'd44100, 18'd44100, 32'd4, 32'd3);
        queue_frame(16'h00FF, 16'hFF00);
        queue_frame(16'hFF00, 16'h00FF);
        queue_frame(16'h0080, 16'h007F);
        queue_frame(16'h0001, 16'h0081);
        drain();
        // upsample by the full ratio, tail repeat on the last frame
        set_clip(2'd2, 1'b1, 18'd8000, 18'd192000, 32'd3, 32'hFFFF_FFFF);
        queue_frame(16'h8000, 16'h8000);
        queue_frame(16'h7FFF, 16'h7FFF);
        queue_frame(16'h8001, 16'h7FFF);
        drain();
        // tiny source rate: long runs of skipped samples
        set_clip(2'd1, 1'b1, 18'd1, 18'd8000, 32'd3, 32'hFFFF_FFFF);
        queue_random(3);
        drain();
        // zero destination rate gives nothing
        set_clip(2'd1, 1'b1, 18'd22050, 18'd0, 32'd2, 32'hFFFF_FFFF);
        queue_random(2);
        drain();
        // no channels: frames counted, no output
        set_clip(2'd0, 1'b1, 18'd0, 18'd48000, 32'd2, 32'hFFFF_FFFF);
        queue_random(2);
        drain();
        // three channels act as stereo, largest source rate
        set_clip(2'd3, 1'b0, 18'h3FFFF, 18'd8000, 32'd2, 32'hFFFF_FFFF);
        queue_random(2);
        drain();
        // one frame while resampling: no output
        set_clip(2'd1, 1'b1, 18'd48000, 18'd44100, 32'd1, 32'hFFFF_FFFF);
        queue_random(1);
        drain();

        // random clips
        while (frames_sent < FRAME_GOAL) begin
            ready_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(20, 90);
            gaps_on   = $urandom_range(0, 3) != 0;
            dst = 18'($urandom_range(8000, 192000));
            case ($urandom_range(0, 5))
                0:       src = 18'd0;
                1:       src = dst;
                default: src = 18'($urandom_range(8000, 192000));
            endcase
            frames = $urandom_range(2, 30);
            nfr    = frames + $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) begin
                frames = 32'hFFFF_FFFF - $urandom_range(0, 3);
                nfr    = $urandom_range(5, 20);
            end
            max_out = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 60))
                                                  : 32'hFFFF_FFFF;
            set_clip(($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3))
                                                 : 2'($urandom_range(1, 2)),
                     1'($urandom), src, dst, frames, max_out);
            queue_random(nfr);
            drain();
        end

        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
